### rtl/core/hfd_pkg.sv
`default_nettype none

package hfd_pkg;

  // Tree and stack sizes.
  localparam int MAX_NODES   = 512;
  localparam int STACK_DEPTH = 256;

  // Derived widths.
  localparam int NODE_AW = $clog2(MAX_NODES);
  localparam int STK_AW  = $clog2(STACK_DEPTH);
  localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
  localparam int USED_W  = $clog2(MAX_NODES + 1);

  // Fixed field widths.
  localparam int SYM_W   = 8;
  localparam int COUNT_W = 32;
  localparam int BITS_W  = 4;

  localparam logic [BITS_W-1:0] SYM_BITS = BITS_W'(SYM_W);

  typedef enum logic [1:0] {
    PH_LOAD   = 2'd0,
    PH_DECODE = 2'd1,
    PH_DONE   = 2'd2,
    PH_STOP   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_SYMBOL    = 2'd0,
    KIND_EARLY_END = 2'd1,
    KIND_NO_CHILD  = 2'd2,
    KIND_OVERFLOW  = 2'd3
  } kind_t;

  typedef struct packed {
    logic stream_bit;
    logic stream_end;
  } in_beat_t;

  typedef struct packed {
    kind_t            result_kind;
    logic [SYM_W-1:0] symbol_byte;
    logic             last;
  } out_beat_t;

  // One node table entry. The left child of an internal node is always the
  // next node in preorder, so only the right child is stored.
  typedef struct packed {
    logic               is_leaf;
    logic [SYM_W-1:0]   symbol;
    logic [NODE_AW-1:0] right;
  } node_ent_t;

  typedef struct packed {
    logic               we;
    logic [NODE_AW-1:0] waddr;
    node_ent_t          wdata;
    logic [NODE_AW-1:0] raddr;
  } node_req_t;

  typedef struct packed {
    logic               we;
    logic [STK_AW-1:0]  waddr;
    logic [NODE_AW-1:0] wdata;
    logic [STK_AW-1:0]  raddr;
  } stk_req_t;

endpackage

`default_nettype wire

### rtl/core/hfd_node_ram.sv
`default_nettype none

module hfd_node_ram (
  input  wire                clk,
  input  hfd_pkg::node_req_t req,
  output hfd_pkg::node_ent_t rdata
);
  import hfd_pkg::*;

  node_ent_t mem [MAX_NODES];
  node_ent_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/core/hfd_stack_ram.sv
`default_nettype none

module hfd_stack_ram (
  input  wire                              clk,
  input  hfd_pkg::stk_req_t                req,
  output logic [hfd_pkg::NODE_AW-1:0]      rdata
);
  import hfd_pkg::*;

  logic [NODE_AW-1:0] mem [STACK_DEPTH];
  logic [NODE_AW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/core/hfd_out_q.sv
`default_nettype none

// Two-entry result queue: the visible output register plus one skid entry.
module hfd_out_q (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  hfd_pkg::out_beat_t push_data,
  output logic               full,
  output logic               out_valid,
  input  wire                out_stall,
  output hfd_pkg::out_beat_t out_data
);
  import hfd_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_beat_t out_data_r, out_data_nxt;
  out_beat_t skid_data_r, skid_data_nxt;
  logic      pop;

  assign pop = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = push;
        skid_data_nxt  = push_data;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = push_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### rtl/core/hfd_ctrl.sv
`default_nettype none

// Tree builder and tree walker. A beat is taken in a cycle that issues the
// memory reads; the next cycle finishes it with the read data.
module hfd_ctrl (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  hfd_pkg::in_beat_t                 in_data,
  input  wire                               cfg_wr_en,
  input  wire  [hfd_pkg::COUNT_W-1:0]       cfg_wr_data,
  input  wire                               outq_full,
  output logic                              push,
  output hfd_pkg::out_beat_t                push_data,
  output hfd_pkg::node_req_t                node_req,
  input  hfd_pkg::node_ent_t                node_rdata,
  output hfd_pkg::stk_req_t                 stk_req,
  input  wire  [hfd_pkg::NODE_AW-1:0]       stk_rdata
);
  import hfd_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic               busy_r;
  logic               bit_r, end_r;
  logic [COUNT_W-1:0] count_r;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [USED_W-1:0]  used_r, used_nxt;
  logic [SYM_W-1:0]   shift_r, shift_nxt;
  logic [BITS_W-1:0]  bits_left_r, bits_left_nxt;
  logic [NODE_AW-1:0] cur_idx_r, cur_idx_nxt;
  node_ent_t          cur_ent_r, cur_ent_nxt;
  node_ent_t          root_r, root_nxt;
  logic [COUNT_W-1:0] bytes_r, bytes_nxt;

  logic               accept;
  logic               cur_leaf;
  logic [NODE_AW-1:0] cur_right;
  logic [NODE_AW-1:0] next_a, next_b;
  logic               add_a, wr_a, n_fits;
  node_ent_t          new_ent_a;
  logic               has_par, pop, stack_full;
  logic [DEPTH_W-1:0] depth_pop;
  logic               leaf_add, int_add;
  logic               wr_b;
  logic [NODE_AW-1:0] wr_b_addr;
  node_ent_t          wr_b_data;
  logic [DEPTH_W-1:0] depth_new;

  assign in_stall = busy_r || outq_full;
  assign accept   = in_valid && !in_stall;

  // The root entry lives in a register so that a walk can restart at once.
  assign cur_leaf  = (cur_idx_r == '0) ? root_r.is_leaf : cur_ent_r.is_leaf;
  assign cur_right = (cur_idx_r == '0) ? root_r.right : cur_ent_r.right;
  assign next_a    = in_data.stream_bit ? cur_right : cur_idx_r + NODE_AW'(1);
  assign next_b    = bit_r ? cur_right : cur_idx_r + NODE_AW'(1);

  assign n_fits = used_r < USED_W'(MAX_NODES);
  assign add_a  = (phase_r == PH_LOAD) && (count_r != '0) && !in_data.stream_end &&
                  ((bits_left_r == BITS_W'(1)) ||
                   ((bits_left_r == '0) && !in_data.stream_bit));
  assign wr_a   = accept && add_a && n_fits;

  always_comb begin
    new_ent_a.is_leaf = (bits_left_r == BITS_W'(1));
    new_ent_a.symbol  = new_ent_a.is_leaf ? {shift_r[SYM_W-2:0], in_data.stream_bit} : '0;
    new_ent_a.right   = '0;
  end

  // Parent of a new node is the top of the stack; it is the right child's
  // parent, and is popped, unless the new node directly follows it.
  assign has_par    = (used_r != '0) && (depth_r != '0);
  assign pop        = has_par && (used_r != USED_W'(stk_rdata) + USED_W'(1));
  assign depth_pop  = depth_r - DEPTH_W'(pop);
  assign stack_full = depth_pop >= DEPTH_W'(STACK_DEPTH);

  always_comb begin
    phase_nxt     = phase_r;
    depth_nxt     = depth_r;
    used_nxt      = used_r;
    shift_nxt     = shift_r;
    bits_left_nxt = bits_left_r;
    cur_idx_nxt   = cur_idx_r;
    cur_ent_nxt   = cur_ent_r;
    root_nxt      = root_r;
    bytes_nxt     = bytes_r;
    wr_b          = 1'b0;
    wr_b_addr     = '0;
    wr_b_data     = '0;
    stk_req.we    = 1'b0;
    stk_req.waddr = '0;
    stk_req.wdata = '0;
    stk_req.raddr = STK_AW'(depth_r - DEPTH_W'(1));
    push          = 1'b0;
    push_data     = '0;
    leaf_add      = 1'b0;
    int_add       = 1'b0;
    depth_new     = depth_pop + DEPTH_W'(1);

    if (wr_a && (used_r == '0)) begin
      root_nxt = new_ent_a;
    end

    if (busy_r && ((phase_r == PH_LOAD) || (phase_r == PH_DECODE))) begin
      if (count_r == '0) begin
        phase_nxt = PH_DONE;
      end else if ((phase_r == PH_DECODE) && (bytes_r >= count_r)) begin
        phase_nxt = PH_DONE;
      end else if (end_r) begin
        phase_nxt             = PH_STOP;
        push                  = 1'b1;
        push_data.result_kind = KIND_EARLY_END;
        push_data.last        = 1'b1;
      end else if (phase_r == PH_LOAD) begin
        if (bits_left_r != '0) begin
          shift_nxt     = {shift_r[SYM_W-2:0], bit_r};
          bits_left_nxt = bits_left_r - BITS_W'(1);
          leaf_add      = (bits_left_r == BITS_W'(1));
        end else if (bit_r) begin
          bits_left_nxt = SYM_BITS;
          shift_nxt     = '0;
        end else begin
          int_add = 1'b1;
        end

        if (leaf_add || int_add) begin
          if (!n_fits || (int_add && stack_full)) begin
            phase_nxt             = PH_STOP;
            push                  = 1'b1;
            push_data.result_kind = KIND_OVERFLOW;
            push_data.last        = 1'b1;
          end else begin
            // The node itself was written when its last bit was taken; here
            // the parent gets its right link and the stack is updated.
            if (pop) begin
              wr_b              = 1'b1;
              wr_b_addr         = stk_rdata;
              wr_b_data.is_leaf = 1'b0;
              wr_b_data.symbol  = '0;
              wr_b_data.right   = used_r[NODE_AW-1:0];
              if (stk_rdata == '0) begin
                root_nxt = wr_b_data;
              end
            end
            if (int_add) begin
              stk_req.we    = 1'b1;
              stk_req.waddr = depth_pop[STK_AW-1:0];
              stk_req.wdata = used_r[NODE_AW-1:0];
              depth_new     = depth_pop + DEPTH_W'(1);
            end else begin
              depth_new = depth_pop;
            end
            depth_nxt = depth_new;
            used_nxt  = used_r + USED_W'(1);
            if (depth_new == '0) begin
              phase_nxt   = PH_DECODE;
              cur_idx_nxt = '0;
            end
          end
        end
      end else begin
        if (cur_leaf) begin
          phase_nxt             = PH_STOP;
          push                  = 1'b1;
          push_data.result_kind = KIND_NO_CHILD;
          push_data.last        = 1'b1;
        end else if (!node_rdata.is_leaf) begin
          cur_idx_nxt = next_b;
          cur_ent_nxt = node_rdata;
        end else begin
          bytes_nxt             = bytes_r + COUNT_W'(1);
          cur_idx_nxt           = '0;
          push                  = 1'b1;
          push_data.result_kind = KIND_SYMBOL;
          push_data.symbol_byte = node_rdata.symbol;
          push_data.last        = (bytes_nxt >= count_r);
          if (bytes_nxt >= count_r) begin
            phase_nxt = PH_DONE;
          end
        end
      end
    end
  end

  always_comb begin
    node_req.we    = wr_a || wr_b;
    node_req.waddr = busy_r ? wr_b_addr : used_r[NODE_AW-1:0];
    node_req.wdata = busy_r ? wr_b_data : new_ent_a;
    node_req.raddr = next_a;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LOAD;
      busy_r      <= 1'b0;
      count_r     <= '0;
      depth_r     <= '0;
      used_r      <= '0;
      bits_left_r <= '0;
      cur_idx_r   <= '0;
      bytes_r     <= '0;
    end else begin
      phase_r     <= phase_nxt;
      busy_r      <= accept;
      if (cfg_wr_en) begin
        count_r <= cfg_wr_data;
      end
      depth_r     <= depth_nxt;
      used_r      <= used_nxt;
      bits_left_r <= bits_left_nxt;
      cur_idx_r   <= cur_idx_nxt;
      bytes_r     <= bytes_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bit_r <= in_data.stream_bit;
      end_r <= in_data.stream_end;
    end
    shift_r   <= shift_nxt;
    cur_ent_r <= cur_ent_nxt;
    root_r    <= root_nxt;
  end

endmodule

`default_nettype wire

### rtl/core/huffman_bitstream_decoder_unit.sv
`default_nettype none

// Huffman bitstream decoder. The compressed stream arrives one bit per input
// beat. The block first rebuilds the code tree from its preorder form (a 1 is
// a leaf followed by its 8-bit symbol MSB first, a 0 an internal node), then
// walks the tree, 0 left and 1 right, and returns one result beat per decoded
// byte until cfg_wr_data's byte count has been produced; the last byte carries
// last. Errors (early stream end, a leaf-only tree with no path, node table or
// stack overflow) give one result beat with last set, after which every input
// beat is taken and ignored, as are all beats once decoding is done or when
// the count is zero. The node table and the stack of pending nodes sit in
// synchronous memories with a registered read. The accepting cycle of an
// input beat issues the table or stack read, the following cycle uses
// the read data to pick the next node or link the new one, so in_stall is
// high while it does so and the block cannot take a new bit before it is
// through with the last one. Results pass through a two-entry output
// queue, so input beats keep flowing while one finished result waits for the
// consumer. The byte count should be written only while the block is idle.
module huffman_bitstream_decoder_unit (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  hfd_pkg::in_beat_t            in_data,
  output logic                         out_valid,
  input  wire                          out_stall,
  output hfd_pkg::out_beat_t           out_data,
  input  wire                          cfg_wr_en,
  input  wire  [hfd_pkg::COUNT_W-1:0]  cfg_wr_data
);
  import hfd_pkg::*;

  node_req_t          node_req;
  node_ent_t          node_rdata;
  stk_req_t           stk_req;
  logic [NODE_AW-1:0] stk_rdata;
  logic               outq_full;
  logic               push;
  out_beat_t          push_data;

  hfd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .outq_full   (outq_full),
    .push        (push),
    .push_data   (push_data),
    .node_req    (node_req),
    .node_rdata  (node_rdata),
    .stk_req     (stk_req),
    .stk_rdata   (stk_rdata)
  );

  // Node table: leaf flag, symbol and right child of every node.
  hfd_node_ram u_node_ram (
    .clk   (clk),
    .req   (node_req),
    .rdata (node_rdata)
  );

  // Internal nodes whose right child has not arrived yet.
  hfd_stack_ram u_stack_ram (
    .clk   (clk),
    .req   (stk_req),
    .rdata (stk_rdata)
  );

  hfd_out_q u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (outq_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
